// ----- hw/rtl/rpq_pkg.sv -----
// Shared types and constants of the ring priority queue.
package rpq_pkg;

  localparam int PRIO_BITS = 4;
  localparam int DATA_BITS = 16;
  localparam int COUNT_BITS = 4;

  localparam logic [PRIO_BITS-1:0] PLAIN_PRIO = 4'd5;
  localparam logic [PRIO_BITS-1:0] HEAD_PRIO = 4'd1;

  typedef logic [PRIO_BITS-1:0] prio_t;

  typedef enum logic [1:0] {
    CMD_PRIO_ENQ  = 2'd0,
    CMD_PLAIN_ENQ = 2'd1,
    CMD_DEQ       = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_RESERVED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_PUSH,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    prio_t    new_prio;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/rpq_if.sv -----
// Request and response channel interfaces of the ring priority queue.
interface rpq_req_if import rpq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  cmd_t                        command;
  logic signed [DATA_BITS-1:0] value_in;
  prio_t                       prio_in;

  modport source(output valid, command, value_in, prio_in, input ready);
  modport sink(input valid, command, value_in, prio_in, output ready);
endinterface

interface rpq_rsp_if import rpq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  status_t                     status;
  logic signed [DATA_BITS-1:0] head_value;
  prio_t                       head_prio;
  logic [COUNT_BITS-1:0]       count;
  logic                        is_empty;
  logic                        is_full;
  logic                        uniform_prio;

  modport source(output valid, status, head_value, head_prio, count, is_empty, is_full,
                 uniform_prio, input ready);
  modport sink(input valid, status, head_value, head_prio, count, is_empty, is_full,
               uniform_prio, output ready);
endinterface

// ----- hw/rtl/rpq_cell.sv -----
// One queue slot in logical order, shifting toward or away from the head.
module rpq_cell import rpq_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic                  prev_valid,
  input  prio_t                 prev_prio,
  input  logic [VALUE_BITS-1:0] prev_value,
  input  logic                  prev_behind,
  input  logic                  next_valid,
  input  prio_t                 next_prio,
  input  logic [VALUE_BITS-1:0] next_value,
  input  logic                  next_behind,
  input  prio_t                 head_prio,
  output logic                  valid,
  output prio_t                 prio,
  output logic [VALUE_BITS-1:0] value,
  output logic                  behind,
  output logic                  mismatch
);

  logic                  valid_next;
  prio_t                 prio_next;
  logic [VALUE_BITS-1:0] value_next;

  // A cell lies at or past the insertion point when no occupied cell from here
  // onward holds a priority at most the new one.
  assign behind   = !(valid && (prio <= ctrl.new_prio)) && next_behind;
  assign mismatch = valid && (prio != head_prio);

  always_comb begin
    valid_next = valid;
    prio_next  = prio;
    value_next = value;
    unique case (ctrl.op)
      OP_APPEND: begin
        if (!valid && prev_valid) begin
          valid_next = 1'b1;
          prio_next  = PLAIN_PRIO;
          value_next = new_value;
        end
      end
      OP_PUSH: begin
        valid_next = prev_valid;
        prio_next  = prev_prio;
        value_next = prev_value;
      end
      OP_INSERT: begin
        if (behind && !prev_behind) begin
          valid_next = 1'b1;
          prio_next  = ctrl.new_prio;
          value_next = new_value;
        end else if (behind) begin
          valid_next = prev_valid;
          prio_next  = prev_prio;
          value_next = prev_value;
        end
      end
      OP_POP: begin
        valid_next = next_valid;
        prio_next  = next_prio;
        value_next = next_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    prio  <= prio_next;
    value <= value_next;
  end

endmodule

// ----- hw/rtl/ring_priority_queue_top.sv -----
// Top level of the ring priority queue: command decode, cell row and result register.
//
//   channel  dir  beat contents
//   req      in   command, value_in, prio_in
//   rsp      out  status, head_value, head_prio, count, is_empty, is_full, uniform_prio
//
// Each enqueue or dequeue shifts or inserts across the whole row of cells at once.
// The response register holds one beat; a new request is taken when it is empty or
// being drained in the same cycle, so a stalled response stalls the request side.
// Reset empties the queue at once; no clearing pass is needed.
module ring_priority_queue_top import rpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8,
  parameter int VALUE_BITS  = 16
) (
  input logic       clk,
  input logic       rst,
  rpq_req_if.sink   req,
  rpq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                  accept;
  logic                  rsp_valid;
  status_t               status;
  status_t               status_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  cell_ctrl_t            ctrl;
  logic                  full;
  logic                  empty;
  logic signed [31:0]    value_ext;
  logic [VALUE_BITS-1:0] new_value;
  logic [31:0]           head_wide;

  logic                  cell_valid  [QUEUE_DEPTH];
  prio_t                 cell_prio   [QUEUE_DEPTH];
  logic [VALUE_BITS-1:0] cell_value  [QUEUE_DEPTH];
  logic                  cell_behind [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] mismatch;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign value_ext = 32'(req.value_in);
  assign new_value = value_ext[VALUE_BITS-1:0];

  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.new_prio = req.prio_in;
    status_next   = ST_DONE;
    count_next    = count;
    if (accept) begin
      unique case (req.command)
        CMD_PRIO_ENQ: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = (req.prio_in == HEAD_PRIO) ? OP_PUSH : OP_INSERT;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_PLAIN_ENQ: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = OP_APPEND;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_DEQ: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.op    = OP_POP;
            count_next = count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                  pv;
    prio_t                 pp;
    logic [VALUE_BITS-1:0] pval;
    logic                  pb;
    logic                  nv;
    prio_t                 np;
    logic [VALUE_BITS-1:0] nval;
    logic                  nb;

    if (i == 0) begin : g_first
      assign pv   = 1'b1;
      assign pp   = ctrl.new_prio;
      assign pval = new_value;
      assign pb   = 1'b0;
    end else begin : g_mid
      assign pv   = cell_valid[i-1];
      assign pp   = cell_prio[i-1];
      assign pval = cell_value[i-1];
      assign pb   = cell_behind[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nv   = 1'b0;
      assign np   = '0;
      assign nval = '0;
      assign nb   = 1'b1;
    end else begin : g_inner
      assign nv   = cell_valid[i+1];
      assign np   = cell_prio[i+1];
      assign nval = cell_value[i+1];
      assign nb   = cell_behind[i+1];
    end

    rpq_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_value  (new_value),
      .prev_valid (pv),
      .prev_prio  (pp),
      .prev_value (pval),
      .prev_behind(pb),
      .next_valid (nv),
      .next_prio  (np),
      .next_value (nval),
      .next_behind(nb),
      .head_prio  (cell_prio[0]),
      .valid      (cell_valid[i]),
      .prio       (cell_prio[i]),
      .value      (cell_value[i]),
      .behind     (cell_behind[i]),
      .mismatch   (mismatch[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      status <= status_next;
    end
  end

  // The queue only changes on an accepted request, so the response fields can
  // be read straight from the cells while the beat waits.
  assign head_wide        = 32'(cell_value[0]);
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = status;
  assign rsp.head_value   = empty ? '0 : head_wide[DATA_BITS-1:0];
  assign rsp.head_prio    = empty ? '0 : cell_prio[0];
  assign rsp.count        = COUNT_BITS'(count);
  assign rsp.is_empty     = empty;
  assign rsp.is_full      = full;
  assign rsp.uniform_prio = !(|mismatch);

endmodule
